// ----- src/rhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types, widths and the restoring-division step used by the RGB to
// HSV pixel converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  // Field widths of the pixel channels and results.
  localparam int CH_W   = 8;
  localparam int HUE_W  = 16;
  localparam int SAT_W  = 16;
  // Quotient bits produced by each division (both are Q0.16 fractions).
  localparam int Q_BITS = 16;
  // Hue divisor is six times the chroma, at most 1530.
  localparam int DEN_W  = 11;
  // Signed width of the hue numerator before the wrap.
  localparam int NUM_W  = 12;
  // Signed width of a channel difference.
  localparam int DIFF_W = CH_W + 1;

  // Sector of the largest channel.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // One input pixel.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_in_t;

  // One converted pixel.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  value;
  } pixel_out_t;

  // Partial state of the two divisions as it moves down the pipeline.
  typedef struct packed {
    logic [DEN_W-1:0]  hue_rem;
    logic [DEN_W-1:0]  hue_den;
    logic [Q_BITS-1:0] hue_quo;
    logic [CH_W-1:0]   sat_rem;
    logic [CH_W-1:0]   sat_den;
    logic [Q_BITS-1:0] sat_quo;
    logic              sat_full;
    logic [CH_W-1:0]   value;
  } div_work_t;

  // One restoring-division step for both the hue and the saturation lanes.
  // Each lane keeps its remainder below its divisor, so one quotient bit is
  // produced per step with a single compare and subtract.
  function automatic div_work_t div_step(div_work_t w);
    logic [DEN_W:0] hue_sh;
    logic [CH_W:0]  sat_sh;
    div_work_t      r;
    r      = w;
    hue_sh = {w.hue_rem, 1'b0};
    sat_sh = {w.sat_rem, 1'b0};
    if (hue_sh >= {1'b0, w.hue_den}) begin
      r.hue_rem = DEN_W'(hue_sh - {1'b0, w.hue_den});
      r.hue_quo = {w.hue_quo[Q_BITS-2:0], 1'b1};
    end else begin
      r.hue_rem = hue_sh[DEN_W-1:0];
      r.hue_quo = {w.hue_quo[Q_BITS-2:0], 1'b0};
    end
    if (sat_sh >= {1'b0, w.sat_den}) begin
      r.sat_rem = CH_W'(sat_sh - {1'b0, w.sat_den});
      r.sat_quo = {w.sat_quo[Q_BITS-2:0], 1'b1};
    end else begin
      r.sat_rem = sat_sh[CH_W-1:0];
      r.sat_quo = {w.sat_quo[Q_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- src/rhsv_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rhsv_div_pipe
// Pipelined restoring divider that produces the hue and saturation quotients
// side by side, STEPS_PER_STAGE quotient bits per register stage.
// ----------------------------------------------------------------------------
module rhsv_div_pipe #(
  parameter int STEPS_PER_STAGE = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rhsv_pkg::div_work_t  in_work,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rhsv_pkg::div_work_t  out_work
);

  localparam int STAGES = rhsv_pkg::Q_BITS / STEPS_PER_STAGE;

  logic                valid_r   [STAGES];
  rhsv_pkg::div_work_t work_r    [STAGES];
  rhsv_pkg::div_work_t work_nxt  [STAGES];
  logic                src_valid [STAGES];
  logic                stage_ready [STAGES];

  // A stage takes a new request when it is empty or its content moves on.
  always_comb begin
    for (int k = STAGES - 1; k >= 0; k--) begin
      if (k == STAGES - 1) begin
        stage_ready[k] = !valid_r[k] || out_ready;
      end else begin
        stage_ready[k] = !valid_r[k] || stage_ready[k+1];
      end
    end
  end

  assign in_ready  = stage_ready[0];
  assign out_valid = valid_r[STAGES-1];
  assign out_work  = work_r[STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    rhsv_pkg::div_work_t src_work;

    // Source of this stage: the pipeline input or the stage before.
    if (k == 0) begin : g_first
      assign src_valid[k] = in_valid;
      assign src_work     = in_work;
    end else begin : g_next
      assign src_valid[k] = valid_r[k-1];
      assign src_work     = work_r[k-1];
    end

    // STEPS_PER_STAGE division steps between registers.
    always_comb begin
      rhsv_pkg::div_work_t w;
      w = src_work;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        w = rhsv_pkg::div_step(w);
      end
      work_nxt[k] = w;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        valid_r[k] <= src_valid[k];
      end
    end

    // Payload of the stage, loaded only when a request moves in.
    always_ff @(posedge clk) begin
      if (stage_ready[k] && src_valid[k]) begin
        work_r[k] <= work_nxt[k];
      end
    end
  end

endmodule

// ----- src/rgb_to_hsv_pixel_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// Converts a stream of 8-bit RGB pixels to HSV: Q0.16 hue, Q0.16 saturation
// and 8-bit value.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the in_ channel (in_valid, in_ready, in_pixel) and leave
// on the out_ channel (out_valid, out_ready, out_pixel), both valid/ready.
// Each accepted request gives exactly one result, in order.
// The pipeline takes one pixel per clock while out_ready is high.
// Its register stages, in order: one stage finds the maximum, minimum and
// sector, one forms the hue numerator and divisors, and the rest are the
// divider stages, each producing DIV_STEPS_PER_STAGE quotient bits of both
// hue and saturation.
// Throughput is set by the divider pipeline, one request per cycle while out_ready is high.
// When out_ready is low the stages fill up and in_ready drops once every
// stage holds a request; nothing is dropped or repeated.
// A synchronous reset (rst_n low) empties the pipeline; results in flight
// are discarded.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top #(
  parameter int DIV_STEPS_PER_STAGE = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rhsv_pkg::pixel_in_t  in_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rhsv_pkg::pixel_out_t out_pixel
);

  localparam int CH_W   = rhsv_pkg::CH_W;
  localparam int DEN_W  = rhsv_pkg::DEN_W;
  localparam int NUM_W  = rhsv_pkg::NUM_W;
  localparam int DIFF_W = rhsv_pkg::DIFF_W;

  // Stage 1 registers.
  logic                     s1_valid_r;
  logic [CH_W-1:0]          s1_value_r;
  logic [CH_W-1:0]          s1_chroma_r;
  rhsv_pkg::sector_t        s1_sector_r;
  logic signed [DIFF_W-1:0] s1_diff_r;
  logic                     s1_ready;

  // Stage 2 registers.
  logic                     s2_valid_r;
  rhsv_pkg::div_work_t      s2_work_r;
  logic                     s2_ready;

  // Divider connections.
  logic                     div_in_ready;
  logic                     div_out_valid;
  rhsv_pkg::div_work_t      div_out_work;

  // Stage 1 next values.
  logic [CH_W-1:0]          s1_value_nxt;
  logic [CH_W-1:0]          s1_min;
  rhsv_pkg::sector_t        s1_sector_nxt;
  logic signed [DIFF_W-1:0] s1_diff_nxt;

  // Stage 2 next values.
  logic [DEN_W-1:0]         c_ext;
  logic [DEN_W-1:0]         den6;
  logic signed [NUM_W-1:0]  sect_off;
  logic signed [NUM_W-1:0]  num;
  logic signed [NUM_W-1:0]  num_wrap;
  rhsv_pkg::div_work_t      s2_work_nxt;

  // Flow control: a stage moves when it is empty or its content moves on.
  assign s2_ready = !s2_valid_r || div_in_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Largest channel with red winning ties over green, green over blue.
  always_comb begin
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    r = in_pixel.red;
    g = in_pixel.green;
    b = in_pixel.blue;
    if (r >= g && r >= b) begin
      s1_value_nxt  = r;
      s1_sector_nxt = rhsv_pkg::SECT_RED;
      s1_diff_nxt   = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g >= b) begin
      s1_value_nxt  = g;
      s1_sector_nxt = rhsv_pkg::SECT_GREEN;
      s1_diff_nxt   = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      s1_value_nxt  = b;
      s1_sector_nxt = rhsv_pkg::SECT_BLUE;
      s1_diff_nxt   = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    s1_min = (r < g) ? r : g;
    if (b < s1_min) begin
      s1_min = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_value_r  <= s1_value_nxt;
      s1_chroma_r <= s1_value_nxt - s1_min;
      s1_sector_r <= s1_sector_nxt;
      s1_diff_r   <= s1_diff_nxt;
    end
  end

  // Hue numerator in sixths of a turn, wrapped into [0, 6C), and divisors.
  always_comb begin
    c_ext = DEN_W'(s1_chroma_r);
    den6  = (c_ext << 2) + (c_ext << 1);
    unique case (s1_sector_r)
      rhsv_pkg::SECT_RED:   sect_off = '0;
      rhsv_pkg::SECT_GREEN: sect_off = $signed({1'b0, c_ext} << 1);
      rhsv_pkg::SECT_BLUE:  sect_off = $signed({1'b0, c_ext} << 2);
      default:              sect_off = '0;
    endcase
    num = sect_off + NUM_W'(s1_diff_r);
    if (num < 0) begin
      num_wrap = num + $signed({1'b0, den6});
    end else begin
      num_wrap = num;
    end

    s2_work_nxt         = '0;
    s2_work_nxt.value   = s1_value_r;
    // A grey pixel divides zero by one, which gives hue zero.
    if (s1_chroma_r == '0) begin
      s2_work_nxt.hue_rem = '0;
      s2_work_nxt.hue_den = DEN_W'(1);
    end else begin
      s2_work_nxt.hue_rem = num_wrap[DEN_W-1:0];
      s2_work_nxt.hue_den = den6;
    end
    // A black pixel divides zero by one; full chroma is forced to all ones.
    if (s1_value_r == '0) begin
      s2_work_nxt.sat_rem  = '0;
      s2_work_nxt.sat_den  = CH_W'(1);
      s2_work_nxt.sat_full = 1'b0;
    end else if (s1_chroma_r == s1_value_r) begin
      s2_work_nxt.sat_rem  = '0;
      s2_work_nxt.sat_den  = s1_value_r;
      s2_work_nxt.sat_full = 1'b1;
    end else begin
      s2_work_nxt.sat_rem  = s1_chroma_r;
      s2_work_nxt.sat_den  = s1_value_r;
      s2_work_nxt.sat_full = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_work_r <= s2_work_nxt;
    end
  end

  // Divider stages for hue and saturation.
  rhsv_div_pipe #(
    .STEPS_PER_STAGE (DIV_STEPS_PER_STAGE)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_ready  (div_in_ready),
    .in_work   (s2_work_r),
    .out_valid (div_out_valid),
    .out_ready (out_ready),
    .out_work  (div_out_work)
  );

  // Result from the last divider register.
  assign out_valid            = div_out_valid;
  assign out_pixel.hue        = div_out_work.hue_quo;
  assign out_pixel.saturation = div_out_work.sat_full ? '1 : div_out_work.sat_quo;
  assign out_pixel.value      = div_out_work.value;

endmodule
